### design/brb_pkg.sv
// Shared types and constants for the byte ring buffer unit.
`timescale 1ns / 1ps

package brb_pkg;

    // Fixed field widths
    localparam int CAP_W   = 11;
    localparam int ACT_W   = 3;
    localparam int CNT_W   = 4;
    localparam int DATA_W  = 64;

    // Parameter defaults
    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_LANES       = 8;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SKIP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    // Status codes
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CNT_W-1:0]  byte_count;
        logic [DATA_W-1:0] write_bytes;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_bytes;
        logic [CNT_W-1:0]  done_count;
        logic              status;
        logic [CAP_W-1:0]  fill_level;
        logic              is_full;
        logic              is_empty;
    } out_item_t;

endpackage

### design/brb_store.sv
// Byte store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module brb_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/brb_seq.sv
// Sequencer: checks each request and walks the bytes one per cycle
// through a shared pointer advance unit.
`timescale 1ns / 1ps

module brb_seq #(
    parameter int STORE_DEPTH = 1024,
    parameter int LANES       = 8,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  brb_pkg::in_item_t       in_data,
    input  logic [brb_pkg::CAP_W-1:0] cap_eff,
    input  logic                    fifo_clear,
    input  logic                    out_free,
    output logic                    res_push,
    output brb_pkg::out_item_t      res_data,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [7:0]              mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  logic [7:0]              mem_rdata
);

    import brb_pkg::*;

    // Width that holds a pointer plus one and any capacity
    localparam int CW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]  wbytes_reg;
    logic [DATA_W-1:0]  rbytes_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               pend_reg;
    logic [2:0]         pend_lane_reg;
    logic [CNT_W-1:0]   done_reg;
    logic               status_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      work_ptr_reg;
    logic [CAP_W-1:0]   held_reg;
    logic               res_push_reg;
    out_item_t          res_data_reg;

    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      ptr_inc;
    logic [AW-1:0]      ptr_adv;
    logic               guard;
    logic [CAP_W-1:0]   held_g;
    logic [AW-1:0]      rd_g;
    logic [AW-1:0]      wr_g;
    logic [CAP_W-1:0]   free_g;
    logic               issue;

    // Shared pointer advance with wrap at capacity
    always_comb
    begin
        cap_ext = CW'(cap_eff);
        ptr_inc = CW'(work_ptr_reg) + CW'(1);
        ptr_adv = (ptr_inc >= cap_ext) ? '0 : ptr_inc[AW-1:0];
    end

    // Stale state from a larger capacity empties the FIFO
    always_comb
    begin
        guard  = (held_reg > cap_eff) || (CW'(rd_ptr_reg) >= cap_ext)
                 || (CW'(wr_ptr_reg) >= cap_ext);
        held_g = guard ? '0 : held_reg;
        rd_g   = guard ? '0 : rd_ptr_reg;
        wr_g   = guard ? '0 : wr_ptr_reg;
        free_g = cap_eff - held_g;
    end

    // Store access
    always_comb
    begin
        issue     = (state_reg == S_READ) && (idx_reg != cnt_reg);
        mem_we    = (state_reg == S_WRITE);
        mem_waddr = work_ptr_reg;
        mem_wdata = wbytes_reg[8 * idx_reg[2:0] +: 8];
        mem_re    = issue;
        mem_raddr = work_ptr_reg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign res_push = res_push_reg;
    assign res_data = res_data_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            held_reg     <= '0;
            pend_reg     <= 1'b0;
            res_push_reg <= 1'b0;
        end
        else
        begin
            res_push_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg    <= in_data.action;
                        cnt_reg    <= in_data.byte_count;
                        wbytes_reg <= in_data.write_bytes;
                        state_reg  <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    rd_ptr_reg <= rd_g;
                    wr_ptr_reg <= wr_g;
                    held_reg   <= held_g;
                    rbytes_reg <= '0;
                    idx_reg    <= '0;
                    pend_reg   <= 1'b0;
                    done_reg   <= '0;
                    status_reg <= STAT_OK;
                    state_reg  <= S_DONE;
                    if (act_reg == ACT_CLEAR)
                    begin
                        rd_ptr_reg <= '0;
                        wr_ptr_reg <= '0;
                        held_reg   <= '0;
                    end
                    else if (act_reg <= ACT_SKIP && cnt_reg != '0)
                    begin
                        if (cnt_reg > CNT_W'(LANES))
                        begin
                            status_reg <= STAT_REJECT;
                        end
                        else if (act_reg == ACT_WRITE)
                        begin
                            if (CAP_W'(cnt_reg) > free_g)
                            begin
                                status_reg <= STAT_REJECT;
                            end
                            else
                            begin
                                work_ptr_reg <= wr_g;
                                state_reg    <= S_WRITE;
                            end
                        end
                        else
                        begin
                            if (CAP_W'(cnt_reg) > held_g)
                            begin
                                status_reg <= STAT_REJECT;
                            end
                            else
                            begin
                                work_ptr_reg <= rd_g;
                                state_reg    <= S_READ;
                            end
                        end
                    end
                end

                // One byte stored per cycle
                S_WRITE:
                begin
                    work_ptr_reg <= ptr_adv;
                    idx_reg      <= idx_reg + CNT_W'(1);
                    if (idx_reg == cnt_reg - CNT_W'(1))
                    begin
                        wr_ptr_reg <= ptr_adv;
                        held_reg   <= held_reg + CAP_W'(cnt_reg);
                        done_reg   <= cnt_reg;
                        state_reg  <= S_DONE;
                    end
                end

                // One address issued per cycle, data lands in the next cycle
                S_READ:
                begin
                    pend_reg <= issue;
                    if (issue)
                    begin
                        work_ptr_reg  <= ptr_adv;
                        idx_reg       <= idx_reg + CNT_W'(1);
                        pend_lane_reg <= idx_reg[2:0];
                    end
                    if (pend_reg && act_reg != ACT_SKIP)
                    begin
                        rbytes_reg[8 * pend_lane_reg +: 8] <= mem_rdata;
                    end
                    if (!issue && !pend_reg)
                    begin
                        if (act_reg != ACT_PEEK)
                        begin
                            rd_ptr_reg <= work_ptr_reg;
                            held_reg   <= held_reg - CAP_W'(cnt_reg);
                        end
                        done_reg  <= cnt_reg;
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        res_push_reg            <= 1'b1;
                        res_data_reg.read_bytes <= rbytes_reg;
                        res_data_reg.done_count <= done_reg;
                        res_data_reg.status     <= status_reg;
                        res_data_reg.fill_level <= held_reg;
                        res_data_reg.is_full    <= (held_reg == cap_eff);
                        res_data_reg.is_empty   <= (held_reg == '0);
                        state_reg               <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Capacity write empties the FIFO (user writes it only while idle; the block does not enforce this)
            if (fifo_clear)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                held_reg   <= '0;
            end
        end
    end

endmodule

### design/byte_ring_buffer_unit.sv
// Top level of the byte ring buffer: capacity register, sequencer, store, result register.
//
// Circular byte FIFO. Each input transaction (in_valid/in_stall, in_data) asks to
// write, read, peek, skip or clear up to LANES bytes carried side by side; the
// request is taken whole or rejected whole. One result transaction
// (out_valid/out_stall, out_data) follows every input transaction, in order.
// Bytes move one per cycle through the store's write and read ports under the sequencer;
// a read, peek or skip closes after its last byte lands. The sequencer's final step
// registers the result and the result register takes it in the next cycle.
// in_stall is high while a transaction is in work. The result register frees the
// sequencer to take the next transaction while a result waits; if out_stall holds
// the previous result, the sequencer waits in its final step until the register frees.
// cfg_we writes capacity_bytes (0 acts as 1, above STORE_DEPTH as STORE_DEPTH) and
// empties the FIFO. Reset empties the FIFO and sets the capacity to 1024 (or STORE_DEPTH
// if smaller); the store itself is not cleared, since only written bytes are ever read back.
`timescale 1ns / 1ps

module byte_ring_buffer_unit #(
    parameter int STORE_DEPTH = brb_pkg::DEF_STORE_DEPTH,
    parameter int LANES       = brb_pkg::DEF_LANES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  brb_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output brb_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]  cfg_wdata
);

    import brb_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic [CAP_W-1:0] cap_eff_reg;
    logic [CAP_W-1:0] cap_eff_next;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic             out_free;
    logic             res_push;
    out_item_t        res_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    // Clamp the written capacity into the usable range
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cap_eff_next = CAP_W'(1);
        end
        else if (int'(cfg_wdata) > STORE_DEPTH)
        begin
            cap_eff_next = CAP_W'(STORE_DEPTH);
        end
        else
        begin
            cap_eff_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_eff_reg <= (int'(CAP_RESET) > STORE_DEPTH) ? CAP_W'(STORE_DEPTH) : CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_eff_reg <= cap_eff_next;
        end
    end

    // Result register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    brb_seq #(
        .STORE_DEPTH (STORE_DEPTH),
        .LANES       (LANES),
        .AW          (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cap_eff    (cap_eff_reg),
        .fifo_clear (cfg_we),
        .out_free   (out_free),
        .res_push   (res_push),
        .res_data   (res_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    brb_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
